FILE: sv/sliding_window_median_defines.svh
// Assertion macros used by the checker file of the median filter
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Implication checked from the next cycle on, muted while reset is held
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication, muted while reset is held
`define SWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that also applies across reset
`define SWM_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/swm_pkg.sv
// Shared types and constants for the sliding window median filter
package swm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int WLEN_W         = 7;
  localparam int OUT_W          = 33;
  localparam int WINDOW_MAX_DEF = 64;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_AGE,
    OP_COMPACT,
    OP_INSERT
  } swm_op_t;

  typedef struct packed {
    swm_op_t                     op;
    logic                        clear;
    logic signed [SAMPLE_W-1:0]  sample;
  } swm_ctrl_t;

endpackage

FILE: sv/swm_cell.sv
// One cell of the sorted window: holds a sample, its age and a valid flag
module swm_cell #(
  parameter int AW = 6,
  parameter int LW = 7
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  swm_pkg::swm_ctrl_t                    ctrl,
  input  logic [LW-1:0]                         len,
  input  logic                                  lo_valid,
  input  logic                                  lo_gt,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]   lo_value,
  input  logic [AW-1:0]                         lo_age,
  input  logic                                  up_valid,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]   up_value,
  input  logic [AW-1:0]                         up_age,
  output logic                                  valid,
  output logic signed [swm_pkg::SAMPLE_W-1:0]   value,
  output logic [AW-1:0]                         age,
  output logic                                  gt,
  output logic                                  hole
);
  import swm_pkg::*;

  logic                        valid_r;
  logic signed [SAMPLE_W-1:0]  value_r;
  logic [AW-1:0]               age_r;
  logic [LW-1:0]               age_inc;

  assign age_inc = LW'(age_r) + LW'(1);
  assign gt      = valid_r && ($signed(value_r) > $signed(ctrl.sample));
  // empty slot under a filled one: the pair swaps during compaction
  assign hole    = !valid_r && up_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      unique case (ctrl.op)
        OP_HOLD: begin
        end
        OP_AGE: begin
          if (ctrl.clear || age_inc >= len) begin
            valid_r <= 1'b0;
          end else begin
            age_r <= age_inc[AW-1:0];
          end
        end
        OP_COMPACT: begin
          if (!valid_r && up_valid) begin
            valid_r <= 1'b1;
            value_r <= up_value;
            age_r   <= up_age;
          end else if (valid_r && !lo_valid) begin
            valid_r <= 1'b0;
          end
        end
        OP_INSERT: begin
          // larger entries shift up one place; new sample lands at the boundary
          if (lo_gt) begin
            valid_r <= 1'b1;
            value_r <= lo_value;
            age_r   <= lo_age;
          end else if (lo_valid && (gt || !valid_r)) begin
            valid_r <= 1'b1;
            value_r <= ctrl.sample;
            age_r   <= '0;
          end
        end
      endcase
    end
  end

  assign valid = valid_r;
  assign value = value_r;
  assign age   = age_r;

endmodule

FILE: sv/sliding_window_median.sv
// Sliding window median filter: sorted chain of cells and its sequencer
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------
//   in       | in_valid/in_ready  | in_sample, in_start_of_stream
//   out      | out_valid/out_ready| out_median_doubled
//   cfg      | cfg_wr_en          | cfg_wr_data (window length)
//
// Each item is aged in, then compacted until the gaps left by evicted entries
// are closed, then inserted, and its median taps are picked; the emit state
// follows only once the window is full.
// Gaps move one cell per cycle through neighbour swaps in the cell chain.
// Reset (synchronous, rst_n low) empties the window and sets the length to 3.
// The result register holds a stalled transfer while the next item is taken;
// that item then waits in its emit cycle until the older result is taken.
module sliding_window_median #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_start_of_stream,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [swm_pkg::OUT_W-1:0]     out_median_doubled,
  input  logic                                 cfg_wr_en,
  input  logic [swm_pkg::WLEN_W-1:0]           cfg_wr_data
);
  import swm_pkg::*;

  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = (LW > WLEN_W) ? LW : WLEN_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_PICK,
    S_EMIT
  } state_t;

  state_t                      state_r;
  logic [WLEN_W-1:0]           window_len_r;
  logic signed [SAMPLE_W-1:0]  sample_r;
  logic signed [SAMPLE_W-1:0]  lo_r;
  logic signed [SAMPLE_W-1:0]  hi_r;
  logic                        out_valid_r;
  logic signed [OUT_W-1:0]     out_median_r;

  logic [CW-1:0]               wl_ext;
  logic [LW-1:0]               len_eff;
  logic [LW-1:0]               lo_idx;
  logic [LW-1:0]               hi_idx;
  logic [LW-1:0]               last_idx;
  swm_ctrl_t                   ctrl;
  logic                        any_hole;
  logic signed [SAMPLE_W-1:0]  lo_pick;
  logic signed [SAMPLE_W-1:0]  hi_pick;
  logic                        full;
  logic signed [OUT_W-1:0]     med_sum;

  logic                        valid_w    [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0]  value_w    [WINDOW_MAX];
  logic [AW-1:0]               age_w      [WINDOW_MAX];
  logic                        gt_w       [WINDOW_MAX];
  logic                        hole_w     [WINDOW_MAX];
  logic                        nb_lo_valid[WINDOW_MAX];
  logic                        nb_lo_gt   [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0]  nb_lo_value[WINDOW_MAX];
  logic [AW-1:0]               nb_lo_age  [WINDOW_MAX];
  logic                        nb_up_valid[WINDOW_MAX];
  logic signed [SAMPLE_W-1:0]  nb_up_value[WINDOW_MAX];
  logic [AW-1:0]               nb_up_age  [WINDOW_MAX];

  // effective length: zero acts as one, saturates at WINDOW_MAX
  assign wl_ext = CW'(window_len_r);
  always_comb begin
    priority if (wl_ext == '0) begin
      len_eff = LW'(1);
    end else if (wl_ext > CW'(WINDOW_MAX)) begin
      len_eff = LW'(WINDOW_MAX);
    end else begin
      len_eff = wl_ext[LW-1:0];
    end
  end

  assign lo_idx   = (len_eff - LW'(1)) >> 1;
  assign hi_idx   = len_eff >> 1;
  assign last_idx = len_eff - LW'(1);

  always_comb begin
    ctrl.clear  = in_start_of_stream;
    ctrl.sample = sample_r;
    unique case (state_r)
      S_IDLE:  ctrl.op = in_valid ? OP_AGE : OP_HOLD;
      S_SORT:  ctrl.op = any_hole ? OP_COMPACT : OP_INSERT;
      default: ctrl.op = OP_HOLD;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < WINDOW_MAX; g++) begin : g_cell
      if (g == 0) begin : g_bottom
        assign nb_lo_valid[g] = 1'b1;
        assign nb_lo_gt[g]    = 1'b0;
        assign nb_lo_value[g] = '0;
        assign nb_lo_age[g]   = '0;
      end else begin : g_lo
        assign nb_lo_valid[g] = valid_w[g-1];
        assign nb_lo_gt[g]    = gt_w[g-1];
        assign nb_lo_value[g] = value_w[g-1];
        assign nb_lo_age[g]   = age_w[g-1];
      end
      if (g == WINDOW_MAX - 1) begin : g_top
        assign nb_up_valid[g] = 1'b0;
        assign nb_up_value[g] = '0;
        assign nb_up_age[g]   = '0;
      end else begin : g_up
        assign nb_up_valid[g] = valid_w[g+1];
        assign nb_up_value[g] = value_w[g+1];
        assign nb_up_age[g]   = age_w[g+1];
      end

      swm_cell #(
        .AW (AW),
        .LW (LW)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .len      (len_eff),
        .lo_valid (nb_lo_valid[g]),
        .lo_gt    (nb_lo_gt[g]),
        .lo_value (nb_lo_value[g]),
        .lo_age   (nb_lo_age[g]),
        .up_valid (nb_up_valid[g]),
        .up_value (nb_up_value[g]),
        .up_age   (nb_up_age[g]),
        .valid    (valid_w[g]),
        .value    (value_w[g]),
        .age      (age_w[g]),
        .gt       (gt_w[g]),
        .hole     (hole_w[g])
      );
    end
  endgenerate

  // gap detect and median taps, AND-OR over the cells
  always_comb begin
    any_hole = 1'b0;
    lo_pick  = '0;
    hi_pick  = '0;
    full     = 1'b0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      any_hole = any_hole | hole_w[i];
      lo_pick  = lo_pick | (value_w[i] & {SAMPLE_W{LW'(i) == lo_idx}});
      hi_pick  = hi_pick | (value_w[i] & {SAMPLE_W{LW'(i) == hi_idx}});
      full     = full | (valid_w[i] && (LW'(i) == last_idx));
    end
  end

  assign med_sum = {lo_r[SAMPLE_W-1], lo_r} + {hi_r[SAMPLE_W-1], hi_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WLEN_RESET;
    end else if (cfg_wr_en) begin
      window_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // in the emit state the result register is reloaded or held instead
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            sample_r <= in_sample;
            state_r  <= S_SORT;
          end
        end
        S_SORT: begin
          if (!any_hole) begin
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          lo_r    <= lo_pick;
          hi_r    <= hi_pick;
          state_r <= full ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_median_r <= med_sum;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_median_doubled = out_median_r;

endmodule

FILE: sv/swm_checker.sv
// Port-level checks for the median filter, bound to the top level
`include "sliding_window_median_defines.svh"

module swm_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [swm_pkg::OUT_W-1:0]     out_median_doubled
);

  `SWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_median_doubled), "stalled result changed")

  `SWM_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken while an item is in work")

  `SWM_ASSERT_NOW(a_no_early_out, $rose(out_valid), !$past(in_valid && in_ready), "result right after an input transfer")

  `SWM_ASSERT_RST(a_reset_clean, !rst_n, !out_valid && in_ready, "not idle after reset")

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);
